// ===== hdl/bado_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, codes and controller/datapath structs for the box average downscaler
// no dependencies

package bado_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int CHANNELS   = 4;

    localparam int PIX_W  = 8;
    localparam int CFG_W  = 13;
    localparam int IDX_W  = 2;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int HSUM_W = 21;
    localparam int SUM_W  = 32;
    localparam int PROD_W = 2 * CFG_W;
    localparam int MUL_W  = HSUM_W + CFG_W;
    localparam int NUM_W  = SUM_W + 2;

    localparam int SDIV_STEPS = CFG_W;
    localparam int ODIV_STEPS = PIX_W;
    localparam int SCNT_W     = $clog2(SDIV_STEPS);
    localparam int OCNT_W     = $clog2(ODIV_STEPS);

    typedef enum logic [IDX_W-1:0] {
        REG_SOURCE_WIDTH,
        REG_SOURCE_HEIGHT,
        REG_FIT_WIDTH,
        REG_FIT_HEIGHT
    } reg_index_t;

    typedef enum logic [1:0] {
        MODE_SCALE,
        MODE_COUNT,
        MODE_BYPASS
    } mode_t;

    typedef logic [CHANNELS-1:0][PIX_W-1:0] pixel_t;

    typedef struct packed {
        logic load;
        logic size_latch;
        logic size_mul;
        logic size_sel;
        logic size_div;
        logic size_fin;
        logic pass;
        logic hacc;
        logic vmul;
        logic vadd;
        logic div_step;
        logic emit;
        logic advance;
    } bado_cmd_t;

    typedef struct packed {
        logic  frame_start;
        mode_t mode;
        logic  need_div;
        logic  sdiv_last;
        logic  col_done;
        logic  row_done;
        logic  odiv_last;
    } bado_status_t;

endpackage

// ===== hdl/bado_if.sv =====
`timescale 1ns / 1ps
// valid/ready channel interfaces for source pixels and averaged pixels
// depends on bado_pkg

interface bado_pix_if import bado_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] in_blue;
    logic [PIX_W-1:0] in_green;
    logic [PIX_W-1:0] in_red;
    logic [PIX_W-1:0] in_alpha;

    modport source (output valid, in_blue, in_green, in_red, in_alpha, input ready);
    modport sink   (input valid, in_blue, in_green, in_red, in_alpha, output ready);
endinterface

interface bado_res_if import bado_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] out_blue;
    logic [PIX_W-1:0] out_green;
    logic [PIX_W-1:0] out_red;
    logic [PIX_W-1:0] out_alpha;
    logic             frame_end;

    modport source (output valid, out_blue, out_green, out_red, out_alpha, frame_end,
                    input ready);
    modport sink   (input valid, out_blue, out_green, out_red, out_alpha, frame_end,
                    output ready);
endinterface

// ===== hdl/bado_ctrl.sv =====
`timescale 1ns / 1ps
// sequencing state machine for the downscaler: issues datapath commands per transaction
// depends on bado_pkg

module bado_ctrl import bado_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    input  bado_status_t status,
    output bado_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SZ_LATCH,
        ST_SZ_MUL,
        ST_SZ_SEL,
        ST_SZ_DIV,
        ST_SZ_FIN,
        ST_DISPATCH,
        ST_HACC,
        ST_VMUL,
        ST_VADD,
        ST_DIV,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = status.frame_start ? ST_SZ_LATCH : ST_DISPATCH;
                end
            end
            ST_SZ_LATCH:
            begin
                cmd.size_latch = 1'b1;
                state_next     = ST_SZ_MUL;
            end
            ST_SZ_MUL:
            begin
                cmd.size_mul = 1'b1;
                state_next   = ST_SZ_SEL;
            end
            ST_SZ_SEL:
            begin
                cmd.size_sel = 1'b1;
                state_next   = status.need_div ? ST_SZ_DIV : ST_SZ_FIN;
            end
            ST_SZ_DIV:
            begin
                cmd.size_div = 1'b1;
                if (status.sdiv_last)
                begin
                    state_next = ST_SZ_FIN;
                end
            end
            ST_SZ_FIN:
            begin
                cmd.size_fin = 1'b1;
                state_next   = ST_DISPATCH;
            end
            ST_DISPATCH:
            begin
                if (status.mode != MODE_SCALE)
                begin
                    cmd.pass    = 1'b1;
                    cmd.advance = (status.mode == MODE_COUNT);
                    state_next  = ST_EMIT;
                end
                else
                begin
                    state_next = ST_HACC;
                end
            end
            ST_HACC:
            begin
                cmd.hacc = 1'b1;
                if (status.col_done)
                begin
                    state_next = ST_VMUL;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_VMUL:
            begin
                cmd.vmul   = 1'b1;
                state_next = ST_VADD;
            end
            ST_VADD:
            begin
                cmd.vadd    = 1'b1;
                cmd.advance = 1'b1;
                state_next  = status.row_done ? ST_DIV : ST_IDLE;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.odiv_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input still ready after a transaction was taken");

    a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("result raised outside the emit step");

    a_single_advance: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.advance |=> !cmd.advance)
        else $error("position advanced twice for one pixel");

endmodule

// ===== hdl/bado_dp.sv =====
`timescale 1ns / 1ps
// downscaler datapath: size setup divider, position tracking, partial sums,
// column store and rounding dividers; depends on bado_pkg

module bado_dp import bado_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  bado_cmd_t          cmd,
    output bado_status_t       status,
    input  logic [CFG_W-1:0]   cfg_source_width,
    input  logic [CFG_W-1:0]   cfg_source_height,
    input  logic [CFG_W-1:0]   cfg_fit_width,
    input  logic [CFG_W-1:0]   cfg_fit_height,
    input  pixel_t             pixel,
    output pixel_t             result,
    output logic               result_frame_end
);

    localparam int WORD_W = 2 * CHANNELS * SUM_W;

    // latched frame setup
    pixel_t             pix_reg;
    logic [CFG_W-1:0]   lw_reg, lh_reg, lfw_reg, lfh_reg, ld_reg, le_reg;
    mode_t              mode_reg, mode_next;
    logic               bypass_reg, fits_reg, branch_w_reg;
    logic [PROD_W-1:0]  prod_hfw_reg, prod_wfh_reg, area_reg;

    // size divider
    logic [PROD_W-1:0]  srem_reg, sden_reg;
    logic [CFG_W-1:0]   squo_reg;
    logic [SCNT_W-1:0]  scnt_reg;
    logic               sge;
    logic [CFG_W-1:0]   squo_fix;

    // position
    logic [COL_W-1:0]   col_reg, col_next, dx_reg, dx_next;
    logic [ROW_W-1:0]   row_reg, row_next, dy_reg, dy_next;
    logic [CFG_W-1:0]   rx_reg, rx_next, ry_reg, ry_next;
    logic [CFG_W:0]     rx_sum, rx_wrap, ry_sum, ry_wrap;
    logic               col_done, col_split, row_done, row_split, col_last, row_last;
    logic [CFG_W-1:0]   left_part, right_part, top_part, bottom_part;

    // sums
    logic [CHANNELS-1:0][HSUM_W-1:0] hsum_reg, hright_reg;
    logic [CHANNELS-1:0][SUM_W-1:0]  ptop_reg, pbot_reg;
    logic [CHANNELS-1:0][SUM_W-1:0]  rd_cur, rd_nxt, cur_new, nxt_new;
    logic [CHANNELS-1:0][MUL_W-1:0]  mul_top, mul_bot;
    logic [WORD_W-1:0]  rd_reg, wr_word;
    logic [WORD_W-1:0]  colmem [MAX_WIDTH];

    // rounding dividers, one lane per channel
    logic [CHANNELS-1:0][NUM_W-1:0]  orem_reg, osub;
    logic [NUM_W-1:0]   oden_reg;
    pixel_t             oquo_reg;
    logic [OCNT_W-1:0]  ocnt_reg;
    logic [CHANNELS-1:0] oge;
    logic               fe_reg;

    // position arithmetic in units of 1/d and 1/e of a source pixel
    always_comb
    begin
        rx_sum      = {1'b0, rx_reg} + {1'b0, ld_reg};
        rx_wrap     = rx_sum - {1'b0, lw_reg};
        col_done    = (rx_sum >= {1'b0, lw_reg});
        col_split   = (rx_sum > {1'b0, lw_reg});
        left_part   = col_split ? (lw_reg - rx_reg) : ld_reg;
        right_part  = col_split ? rx_wrap[CFG_W-1:0] : '0;
        ry_sum      = {1'b0, ry_reg} + {1'b0, le_reg};
        ry_wrap     = ry_sum - {1'b0, lh_reg};
        row_done    = (ry_sum >= {1'b0, lh_reg});
        row_split   = (ry_sum > {1'b0, lh_reg});
        top_part    = row_split ? (lh_reg - ry_reg) : le_reg;
        bottom_part = row_split ? ry_wrap[CFG_W-1:0] : '0;
        col_last    = (CFG_W'(col_reg) == (lw_reg - 1'b1));
        row_last    = (CFG_W'(row_reg) == (lh_reg - 1'b1));
        sge         = (srem_reg >= sden_reg);
        squo_fix    = (squo_reg == '0) ? CFG_W'(1) : squo_reg;
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        rx_next  = rx_reg;
        ry_next  = ry_reg;
        dx_next  = dx_reg;
        dy_next  = dy_reg;
        if (cmd.size_latch)
        begin
            col_next = '0;
            row_next = '0;
            rx_next  = '0;
            ry_next  = '0;
            dx_next  = '0;
            dy_next  = '0;
        end
        else if (cmd.advance)
        begin
            if (col_last)
            begin
                col_next = '0;
                rx_next  = '0;
                dx_next  = '0;
                if (row_last)
                begin
                    row_next = '0;
                    ry_next  = '0;
                    dy_next  = '0;
                end
                else
                begin
                    row_next = row_reg + 1'b1;
                    if (row_done)
                    begin
                        ry_next = ry_wrap[CFG_W-1:0];
                        dy_next = dy_reg + 1'b1;
                    end
                    else
                    begin
                        ry_next = ry_sum[CFG_W-1:0];
                    end
                end
            end
            else
            begin
                col_next = col_reg + 1'b1;
                if (col_done)
                begin
                    rx_next = rx_wrap[CFG_W-1:0];
                    dx_next = dx_reg + 1'b1;
                end
                else
                begin
                    rx_next = rx_sum[CFG_W-1:0];
                end
            end
        end
    end

    always_comb
    begin
        mode_next = mode_reg;
        if (cmd.size_latch)
        begin
            mode_next = MODE_BYPASS;
        end
        else if (cmd.size_fin)
        begin
            if (bypass_reg)
            begin
                mode_next = MODE_BYPASS;
            end
            else if (fits_reg)
            begin
                mode_next = MODE_COUNT;
            end
            else if (branch_w_reg)
            begin
                mode_next = (lfw_reg == lw_reg && squo_fix == lh_reg) ? MODE_COUNT : MODE_SCALE;
            end
            else
            begin
                mode_next = (squo_fix == lw_reg && lfh_reg == lh_reg) ? MODE_COUNT : MODE_SCALE;
            end
        end
    end

    // column store words: current-row sums low, next-row sums high
    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            rd_cur[c]  = (row_reg == '0) ? '0 : rd_reg[c*SUM_W +: SUM_W];
            rd_nxt[c]  = (row_reg == '0) ? '0 : rd_reg[(CHANNELS+c)*SUM_W +: SUM_W];
            cur_new[c] = rd_cur[c] + ptop_reg[c];
            nxt_new[c] = rd_nxt[c] + pbot_reg[c];
            mul_top[c] = MUL_W'(hsum_reg[c]) * MUL_W'(top_part);
            mul_bot[c] = MUL_W'(hsum_reg[c]) * MUL_W'(bottom_part);
            oge[c]     = (orem_reg[c] >= oden_reg);
            osub[c]    = orem_reg[c] - oden_reg;
            if (row_done)
            begin
                wr_word[c*SUM_W +: SUM_W]            = nxt_new[c];
                wr_word[(CHANNELS+c)*SUM_W +: SUM_W] = '0;
            end
            else
            begin
                wr_word[c*SUM_W +: SUM_W]            = cur_new[c];
                wr_word[(CHANNELS+c)*SUM_W +: SUM_W] = nxt_new[c];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.hacc)
        begin
            rd_reg <= colmem[dx_reg];
        end
        if (cmd.vadd)
        begin
            colmem[dx_reg] <= wr_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            rx_reg   <= '0;
            ry_reg   <= '0;
            dx_reg   <= '0;
            dy_reg   <= '0;
            mode_reg <= MODE_BYPASS;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            rx_reg   <= rx_next;
            ry_reg   <= ry_next;
            dx_reg   <= dx_next;
            dy_reg   <= dy_next;
            mode_reg <= mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pix_reg <= pixel;
        end
        if (cmd.size_latch)
        begin
            lw_reg   <= cfg_source_width;
            lh_reg   <= cfg_source_height;
            lfw_reg  <= cfg_fit_width;
            lfh_reg  <= cfg_fit_height;
            hsum_reg <= '0;
        end
        if (cmd.size_mul)
        begin
            prod_hfw_reg <= PROD_W'(lh_reg) * PROD_W'(lfw_reg);
            prod_wfh_reg <= PROD_W'(lw_reg) * PROD_W'(lfh_reg);
            area_reg     <= PROD_W'(lw_reg) * PROD_W'(lh_reg);
            bypass_reg   <= (lw_reg == '0) || (lh_reg == '0) || (lfw_reg == '0)
                            || (lfh_reg == '0)
                            || (PROD_W'(lw_reg) > PROD_W'(MAX_WIDTH))
                            || (PROD_W'(lh_reg) > PROD_W'(MAX_HEIGHT));
            fits_reg     <= (lfw_reg >= lw_reg) && (lfh_reg >= lh_reg);
        end
        if (cmd.size_sel)
        begin
            branch_w_reg <= (prod_hfw_reg <= prod_wfh_reg);
            squo_reg     <= '0;
            scnt_reg     <= SCNT_W'(SDIV_STEPS - 1);
            if (prod_hfw_reg <= prod_wfh_reg)
            begin
                srem_reg <= prod_hfw_reg;
                sden_reg <= PROD_W'(lw_reg) << (SDIV_STEPS - 1);
            end
            else
            begin
                srem_reg <= prod_wfh_reg;
                sden_reg <= PROD_W'(lh_reg) << (SDIV_STEPS - 1);
            end
        end
        if (cmd.size_div)
        begin
            if (sge)
            begin
                srem_reg <= srem_reg - sden_reg;
            end
            squo_reg <= {squo_reg[CFG_W-2:0], sge};
            sden_reg <= sden_reg >> 1;
            scnt_reg <= scnt_reg - 1'b1;
        end
        if (cmd.size_fin)
        begin
            if (bypass_reg || fits_reg)
            begin
                ld_reg <= lw_reg;
                le_reg <= lh_reg;
            end
            else if (branch_w_reg)
            begin
                ld_reg <= lfw_reg;
                le_reg <= squo_fix;
            end
            else
            begin
                ld_reg <= squo_fix;
                le_reg <= lfh_reg;
            end
        end
        if (cmd.pass)
        begin
            fe_reg <= (mode_reg == MODE_COUNT) && col_last && row_last;
        end
        if (cmd.hacc)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                hsum_reg[c]   <= hsum_reg[c] + HSUM_W'(pix_reg[c]) * HSUM_W'(left_part);
                hright_reg[c] <= HSUM_W'(pix_reg[c]) * HSUM_W'(right_part);
            end
        end
        if (cmd.vmul)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                ptop_reg[c] <= mul_top[c][SUM_W-1:0];
                pbot_reg[c] <= mul_bot[c][SUM_W-1:0];
            end
        end
        if (cmd.vadd)
        begin
            hsum_reg <= hright_reg;
            fe_reg   <= (CFG_W'(dy_reg) == (le_reg - 1'b1))
                        && (CFG_W'(dx_reg) == (ld_reg - 1'b1));
            // rounding half up: (2s + area) / (2 area)
            for (int c = 0; c < CHANNELS; c++)
            begin
                orem_reg[c] <= {1'b0, cur_new[c], 1'b0} + NUM_W'(area_reg);
            end
            oden_reg <= NUM_W'({area_reg, 1'b0}) << (ODIV_STEPS - 1);
            ocnt_reg <= OCNT_W'(ODIV_STEPS - 1);
        end
        if (cmd.div_step)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                if (oge[c])
                begin
                    orem_reg[c] <= osub[c];
                end
                oquo_reg[c] <= {oquo_reg[c][PIX_W-2:0], oge[c]};
            end
            oden_reg <= oden_reg >> 1;
            ocnt_reg <= ocnt_reg - 1'b1;
        end
        if (cmd.emit)
        begin
            result           <= (mode_reg == MODE_SCALE) ? oquo_reg : pix_reg;
            result_frame_end <= fe_reg;
        end
    end

    always_comb
    begin
        status.frame_start = (col_reg == '0) && (row_reg == '0);
        status.mode        = mode_reg;
        status.need_div    = !bypass_reg && !fits_reg;
        status.sdiv_last   = (scnt_reg == '0);
        status.col_done    = col_done;
        status.row_done    = row_done;
        status.odiv_last   = (ocnt_reg == '0);
    end

    a_rx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_SCALE) |-> (rx_reg < lw_reg))
        else $error("column remainder out of range");

    a_ry_range: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_SCALE) |-> (ry_reg < lh_reg))
        else $error("row remainder out of range");

    a_dx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_SCALE) |-> (CFG_W'(dx_reg) < ld_reg))
        else $error("output column beyond scaled width");

endmodule

// ===== hdl/box_average_downscale_to_fit.sv =====
`timescale 1ns / 1ps
// steps per source pixel: load, dispatch, horizontal accumulate; closing an output column
//   adds vertical multiply and add; completing an output pixel adds the 8-step rounding
//   divider and the emit step, which waits while a held result is not taken; pass-through
//   pixels go from dispatch to emit; a frame start adds size setup, with its 13-step divider when scaling
// reset: sizes go to 640 x 480, position counters to zero; no clearing pass, the column
//   store reads as zero throughout the first source row of every frame

module box_average_downscale_to_fit import bado_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             write_enable,
    input  logic [IDX_W-1:0] reg_index,
    input  logic [CFG_W-1:0] write_data,
    bado_pix_if.sink         pixels,
    bado_res_if.source       averages
);

    // configuration registers, sampled by the datapath at each frame start
    logic [CFG_W-1:0] source_width_reg;
    logic [CFG_W-1:0] source_height_reg;
    logic [CFG_W-1:0] fit_width_reg;
    logic [CFG_W-1:0] fit_height_reg;

    bado_cmd_t    cmd;
    bado_status_t status;
    pixel_t       pixel;
    pixel_t       result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_width_reg  <= CFG_W'(640);
            source_height_reg <= CFG_W'(480);
            fit_width_reg     <= CFG_W'(640);
            fit_height_reg    <= CFG_W'(480);
        end
        else if (write_enable)
        begin
            case (reg_index)
                REG_SOURCE_WIDTH:  source_width_reg  <= write_data;
                REG_SOURCE_HEIGHT: source_height_reg <= write_data;
                REG_FIT_WIDTH:     fit_width_reg     <= write_data;
                REG_FIT_HEIGHT:    fit_height_reg    <= write_data;
                default:           source_width_reg  <= source_width_reg;
            endcase
        end
    end

    // channel order inside the datapath: blue, green, red, alpha
    assign pixel[0] = pixels.in_blue;
    assign pixel[1] = pixels.in_green;
    assign pixel[2] = pixels.in_red;
    assign pixel[3] = pixels.in_alpha;

    assign averages.out_blue  = result[0];
    assign averages.out_green = result[1];
    assign averages.out_red   = result[2];
    assign averages.out_alpha = result[3];

    // sequencer: one source transaction at a time, output register parts the sides
    bado_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pixels.valid),
        .in_ready  (pixels.ready),
        .out_valid (averages.valid),
        .out_ready (averages.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // sums, column store and dividers
    bado_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .cfg_source_width  (source_width_reg),
        .cfg_source_height (source_height_reg),
        .cfg_fit_width     (fit_width_reg),
        .cfg_fit_height    (fit_height_reg),
        .pixel             (pixel),
        .result            (result),
        .result_frame_end  (averages.frame_end)
    );

endmodule
